// ===== sv/rfs_pkg.sv =====
// Shared constants, codes and types of the ring FIFO with search.
package rfs_pkg;

	localparam int DEPTH       = 16;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;
	localparam int OUT_BITS    = VAL_W + PTR_W + CNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_FIND = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic [PTR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] data;
		logic [PTR_W-1:0] slot;
		logic [CNT_W-1:0] count;
	} result_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== sv/rfs_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rfs_seq.sv =====
// Command sequencer: pointers, occupancy, capacity register and the scan compare.
module rfs_seq
	import rfs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             in_cmd,
	input  logic [VAL_W-1:0] in_value,
	output ram_req_t         ram_req,
	input  logic [VAL_W-1:0] ram_rdata,
	output result_t          res,
	output logic             res_valid,
	input  logic             res_take
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CAP_W-1:0] cap_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] idx_q;
	cmd_t             cmd_q;
	logic [VAL_W-1:0] val_q;
	status_t          status_q;
	logic [VAL_W-1:0] data_q;
	logic [PTR_W-1:0] slot_q;

	logic in_fire;
	logic full;
	logic empty;
	logic hit;
	logic last;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign empty    = (occ_q == '0);
	assign full     = (occ_q == CNT_W'(DEPTH)) || (CMP_W'(occ_q) >= CMP_W'(cap_q));
	assign hit      = (ram_rdata == val_q);
	assign last     = ((idx_q + CNT_W'(1)) == occ_q);

	always_comb begin
		ram_req.we    = in_fire && (in_cmd == CMD_ENQ) && !full;
		ram_req.waddr = tail_q;
		ram_req.wdata = in_value;
		// keep one read in flight ahead of the compare while scanning
		ram_req.raddr = (state_q == S_SCAN) ? next_slot(ptr_q) : head_q;
	end

	assign res.status = status_q;
	assign res.data   = data_q;
	assign res.slot   = slot_q;
	assign res.count  = occ_q;
	assign res_valid  = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= CAP_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			ptr_q    <= '0;
			occ_q    <= '0;
			idx_q    <= '0;
			cmd_q    <= CMD_ENQ;
			val_q    <= '0;
			status_q <= ST_OK;
			data_q   <= '0;
			slot_q   <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cmd_q    <= in_cmd;
						val_q    <= in_value;
						data_q   <= '0;
						slot_q   <= '0;
						status_q <= ST_OK;
						case (in_cmd)
							CMD_ENQ: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									tail_q <= next_slot(tail_q);
									occ_q  <= occ_q + CNT_W'(1);
								end
								state_q <= S_DONE;
							end
							CMD_DEQ, CMD_PEEK: begin
								if (empty) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_FETCH;
								end
							end
							CMD_FIND: begin
								if (empty) begin
									status_q <= ST_NOTFOUND;
									state_q  <= S_DONE;
								end else begin
									ptr_q   <= head_q;
									idx_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_FETCH: begin
					data_q <= ram_rdata;
					if (cmd_q == CMD_DEQ) begin
						head_q <= next_slot(head_q);
						occ_q  <= occ_q - CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						slot_q  <= ptr_q;
						state_q <= S_DONE;
					end else if (last) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_DONE;
					end else begin
						ptr_q <= next_slot(ptr_q);
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_cmd == CMD_ENQ) && !full) |=> (occ_q == $past(occ_q) + CNT_W'(1)))
		else $error("accepted enqueue did not grow occupancy");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q < occ_q))
		else $error("scan index past occupancy");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !res_take) |=> ((state_q == S_DONE) && $stable(status_q)))
		else $error("result dropped before hand-off");
`endif

endmodule

// ===== sv/ring_fifo_with_search_unit.sv =====
// Top level of the ring FIFO with search: stream ports and output register.
// One command beat is taken at a time. Enqueue, and any command answered
// empty, full or not found without a lookup, goes straight to the done
// state; dequeue and peek pass a fetch state (one registered read of the
// entry RAM); find compares entries one per cycle via the single RAM read
// port. A finished result sits in the output register while the next
// command is taken. The user makes capacity writes only while the block
// is idle (not enforced here); the entry RAM needs no clearing after reset.
module ring_fifo_with_search_unit
	import rfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VAL_W-1:0]       s_tdata,   // value
	input  logic [1:0]             s_tuser,   // cmd
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // data, slot, count, zero pad
	output logic [1:0]             m_tuser    // status
);

	ram_req_t         ram_req;
	logic [VAL_W-1:0] ram_rdata;
	result_t          res;
	logic             res_valid;
	logic             res_take;

	logic             m_tvalid_q;
	result_t          out_q;

	rfs_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	rfs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (cmd_t'(s_tuser)),
		.in_value (s_tdata),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.res      (res),
		.res_valid(res_valid),
		.res_take (res_take)
	);

	// load when the output register is empty or its beat leaves this cycle
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = OUT_TDATA_W'({out_q.count, out_q.slot, out_q.data});

endmodule
